### rtl/drld_pkg.sv
// Shared types and constants of the decimal run-length decoder.
// Used by drld_front, drld_fifo, drld_back and the top level.
package drld_pkg;

  localparam logic [7:0] DIGIT_LO     = 8'h30;
  localparam logic [7:0] DIGIT_HI     = 8'h39;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [3:0] COUNT_SAT    = 4'd8;
  localparam logic [3:0] COUNT_BIG    = 4'd7;
  localparam logic [4:0] MOD_BASE     = 5'd7;
  localparam logic [2:0] MAX_COPIES   = 3'd6;

  // One decoded request: copies of rep_byte, then byte_val, then a newline.
  typedef struct packed {
    logic [2:0] copies;
    logic [7:0] rep_byte;
    logic       has_byte;
    logic [7:0] byte_val;
    logic       has_nl;
  } drld_cmd_t;

  // Reduce a value below 28 mod 7 with two compare-subtract steps.
  function automatic logic [2:0] mod7_reduce(input logic [4:0] x);
    logic [4:0] v;
    v = x;
    if (v >= (MOD_BASE << 1)) v = v - (MOD_BASE << 1);
    if (v >= MOD_BASE) v = v - MOD_BASE;
    return v[2:0];
  endfunction

endpackage

### rtl/drld_front.sv
// Front end: accepts encoded bytes, tracks the digit count and builds
// requests for the back end. Depends on drld_pkg.
module drld_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                is_final,
  output logic                push,
  output drld_pkg::drld_cmd_t push_cmd,
  input  logic                q_full
);
  import drld_pkg::*;

  logic [7:0] repeat_byte;
  logic [3:0] count_small;
  logic [2:0] count_mod_seven;
  logic       digits_pending;

  logic       accept;
  logic       is_digit;
  logic [3:0] digit;
  logic [6:0] sum_small;
  logic [3:0] small_new;
  logic [2:0] mod_new;
  logic [3:0] eff_small;
  logic [2:0] eff_mod;
  logic       eff_pending;
  logic [2:0] copies;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Classify the byte and fold a digit into the count
  assign is_digit  = (in_byte >= DIGIT_LO) && (in_byte <= DIGIT_HI);
  assign digit     = in_byte[3:0];
  assign sum_small = {3'b000, count_small} * 7'd10 + {3'b000, digit};
  assign small_new = (sum_small > {3'b000, COUNT_SAT}) ? COUNT_SAT : sum_small[3:0];
  assign mod_new   = mod7_reduce({2'b00, count_mod_seven} * 5'd3 + {1'b0, digit});

  // A digit that is also final ends its own run
  assign eff_small   = is_digit ? small_new : count_small;
  assign eff_mod     = is_digit ? mod_new : count_mod_seven;
  assign eff_pending = is_digit || digits_pending;

  always_comb begin
    copies = 3'd0;
    if (eff_pending) begin
      if (eff_small > COUNT_BIG) begin
        copies = eff_mod;
      end else if (eff_small != 4'd0) begin
        copies = 3'(eff_small - 4'd1);
      end
    end
  end

  // Build the request; a digit that is not final yields nothing
  assign push              = accept && (!is_digit || is_final);
  assign push_cmd.copies   = copies;
  assign push_cmd.rep_byte = repeat_byte;
  assign push_cmd.has_byte = !is_digit;
  assign push_cmd.byte_val = in_byte;
  assign push_cmd.has_nl   = is_final;

  // Advance the count state
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_byte     <= 8'd0;
      count_small     <= 4'd0;
      count_mod_seven <= 3'd0;
      digits_pending  <= 1'b0;
    end else if (accept) begin
      priority if (is_final) begin
        repeat_byte     <= 8'd0;
        count_small     <= 4'd0;
        count_mod_seven <= 3'd0;
        digits_pending  <= 1'b0;
      end else if (is_digit) begin
        count_small     <= small_new;
        count_mod_seven <= mod_new;
        digits_pending  <= 1'b1;
      end else begin
        repeat_byte     <= in_byte;
        count_small     <= 4'd0;
        count_mod_seven <= 3'd0;
        digits_pending  <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count_small <= COUNT_SAT) && (count_mod_seven < 3'd7))
    else $error("count out of range");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    !digits_pending |-> (count_small == 4'd0) && (count_mod_seven == 3'd0))
    else $error("count held without a pending run");

endmodule

### rtl/drld_fifo.sv
// Short request queue between front and back end.
// Depends on drld_pkg for the request type.
module drld_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  drld_pkg::drld_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output drld_pkg::drld_cmd_t pop_cmd,
  output logic                not_empty
);
  import drld_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  drld_cmd_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slots[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + 1'b1))
    else $error("fill count lost a push");

endmodule

### rtl/drld_back.sv
// Back end: expands one request into result bytes, one per cycle while the
// output is not stalled, through a registered output stage. Depends on drld_pkg.
module drld_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  drld_pkg::drld_cmd_t q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                run_last
);
  import drld_pkg::*;

  drld_cmd_t  cmd;
  logic       cmd_valid;
  drld_cmd_t  cmd_next;
  logic [7:0] res_byte;
  logic       res_last;
  logic       out_load;

  // Pick the next result and what remains after it
  always_comb begin
    cmd_next = cmd;
    if (cmd.copies != 3'd0) begin
      res_byte        = cmd.rep_byte;
      cmd_next.copies = cmd.copies - 3'd1;
    end else if (cmd.has_byte) begin
      res_byte          = cmd.byte_val;
      cmd_next.has_byte = 1'b0;
    end else begin
      res_byte        = NEWLINE_BYTE;
      cmd_next.has_nl = 1'b0;
    end
    res_last = (cmd_next.copies == 3'd0) && !cmd_next.has_byte && !cmd_next.has_nl;
  end

  assign out_load = cmd_valid && (!out_valid || !out_stall);
  assign pop      = !cmd_valid || (out_load && res_last);

  // Hold or refill the working request
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (pop) begin
      cmd_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end else if (out_load) begin
      cmd <= cmd_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= res_byte;
      run_last <= res_last;
    end
  end

  a_cmd_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd.has_byte || cmd.has_nl))
    else $error("working request has no final result");

  a_copies_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd.copies <= MAX_COPIES))
    else $error("copy count out of range");

endmodule

### rtl/decimal_run_length_decoder_top.sv
// Decimal run-length decoder, top level. A result goes from its accepted byte
// through the request queue, the working request of the back end and its output register.
// Throughput: one result per cycle while the output is not stalled; an item causes
// 0 to 8 results, each sent through the single output register of the back end.
// The front keeps taking bytes while fewer than QUEUE_DEPTH requests wait.
// Reset clears the count state, the queue and the output register.
module decimal_run_length_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import drld_pkg::*;

  logic      push;
  drld_cmd_t push_cmd;
  logic      q_full;
  logic      pop;
  drld_cmd_t pop_cmd;
  logic      q_not_empty;

  // Classify bytes and track counts
  drld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .is_final (is_final),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Decouple front and back
  drld_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty)
  );

  // Expand requests into result bytes
  drld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (pop_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

endmodule

### verif/decimal_run_length_decoder_top_tb.sv
// Self-checking testbench for decimal_run_length_decoder_top: drives encoded strings
// byte by byte and compares every decoded byte against an in-bench decode model.
// Depends only on the RTL under rtl/ (top level and drld_pkg).
module decimal_run_length_decoder_top_tb;

  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] NINE_CHAR = 8'h39;
  localparam logic [7:0] NEWLINE   = 8'd10;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [7:0] out_val;
    logic       last;
  } decoded_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       is_final  = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  decimal_run_length_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  // Decoder state mirrored by the bench
  logic [7:0] rep_byte = 8'h00;
  logic [3:0] cnt_sat  = 4'd0;
  logic [2:0] cnt_mod7 = 3'd0;
  logic       run_open = 1'b0;

  decoded_t decoded_q[$];
  int n_requests = 0;
  int n_results  = 0;
  int n_messages = 0;
  int n_errors   = 0;
  int cycles     = 0;
  int burst_left = 0;
  bit hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
      $display("decimal_run_length_decoder_top_tb: FAIL");
      $finish;
    end
  end

  task automatic push_result(input logic [7:0] v);
    decoded_q.push_back('{out_val: v, last: 1'b0});
  endtask

  // End a pending digit run: emit the extra copies, clear the count
  task automatic close_run();
    int copies;
    copies = 0;
    if (run_open) begin
      if (cnt_sat > 4'd7) copies = int'(cnt_mod7);
      else if (cnt_sat > 4'd0) copies = int'(cnt_sat) - 1;
      repeat (copies) push_result(rep_byte);
    end
    run_open = 1'b0;
    cnt_sat  = 4'd0;
    cnt_mod7 = 3'd0;
  endtask

  // Expected output bytes for one accepted request
  task automatic predict_decode(input logic [7:0] b, input logic fin);
    int first;
    int d;
    int s;
    first = decoded_q.size();
    if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
      d        = int'(b) - int'(ZERO_CHAR);
      s        = int'(cnt_sat) * 10 + d;
      run_open = 1'b1;
      cnt_sat  = (s > 8) ? 4'd8 : s[3:0];
      cnt_mod7 = 3'((int'(cnt_mod7) * 3 + d) % 7);
    end else begin
      close_run();
      push_result(b);
      rep_byte = b;
    end
    if (fin) begin
      close_run();
      push_result(NEWLINE);
      rep_byte = 8'h00;
      n_messages++;
    end
    if (decoded_q.size() > first) decoded_q[$].last = 1'b1;
  endtask

  // Offer one request and hold it until accepted
  task automatic apply_byte(input logic [7:0] b, input logic fin);
    bit taken;
    in_valid <= 1'b1;
    in_byte  <= b;
    is_final <= fin;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) predict_decode(b, fin);
      @(posedge clk);
    end while (!taken);
    n_requests++;
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send in bursts with random gaps between them
  task automatic paced_byte(input logic [7:0] b, input logic fin);
    apply_byte(b, fin);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_input($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        do b = 8'($urandom_range(0, 255)); while (b >= ZERO_CHAR && b <= NINE_CHAR);
      end
      3: b = NEWLINE;
      default: b = 8'h61 + 8'($urandom_range(0, 25));
    endcase
    return b;
  endfunction

  function automatic void add_digits(ref logic [7:0] msg[$]);
    int r;
    int len;
    r   = $urandom_range(0, 9);
    len = (r < 5) ? 1 : (r < 8) ? 2 : $urandom_range(3, 7);
    repeat (len) msg.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
  endfunction

  // Check each accepted output byte against the oldest expectation
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin : check_result
      decoded_t want;
      n_results++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result out_byte=%0h run_last=%0b", out_byte, run_last);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.out_val) begin
          $error("out_byte expected %0h actual %0h", want.out_val, out_byte);
          n_errors++;
        end
        if (run_last !== want.last) begin
          $error("run_last expected %0b actual %0b", want.last, run_last);
          n_errors++;
        end
      end
    end
  end

  // Output stall pattern; a requested hold-off is counted here
  initial begin
    rx_mode_t mode;
    int mode_left;
    int hold_left;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLDOFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Corner cases: leading digits, zero count, remainder zero, saturated count, max fan-out
  task automatic test_directed_cases();
    logic [7:0] seq [23] = '{
      8'h33, 8'h00,               // digits first repeat the reset byte
      8'hFF, 8'h30, 8'h2F,        // count of zero
      8'h31, 8'h34, 8'h3A,        // fourteen: remainder zero
      8'h37, 8'h62,               // seven then final plain byte: eight results
      8'h39,                      // lone final digit after a message end
      8'h61, 8'h31, 8'h38,        // eighteen ended by final
      8'h63, 8'h39, 8'h39, 8'h39, 8'h39, 8'h0A, // saturated count, newline input
      8'h78, 8'h31, 8'h79         // count of one
    };
    bit fin_at [23] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 1};
    for (int i = 0; i < 23; i++) apply_byte(seq[i], fin_at[i]);
    wait_drained();
  endtask

  // Well-formed encoded strings with random content
  task automatic test_random_messages();
    logic [7:0] msg[$];
    while (n_requests < 280) begin
      msg = {};
      if ($urandom_range(0, 9) == 0) add_digits(msg);
      repeat ($urandom_range(1, 8)) begin
        msg.push_back(pick_plain());
        if ($urandom_range(0, 1) == 1) add_digits(msg);
      end
      foreach (msg[i]) paced_byte(msg[i], i == msg.size() - 1);
    end
    wait_drained();
  endtask

  // Long output hold-off while requests keep coming, then pause until drained
  task automatic test_output_holdoff();
    hold_req = 1'b1;
    for (int i = 0; i < 36; i++)
      apply_byte((i % 2 == 0) ? pick_plain() : 8'h37, i == 35 || $urandom_range(0, 9) == 0);
    wait_drained();
  endtask

  // Raw byte noise with random final flags
  task automatic test_raw_noise();
    repeat (40) paced_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    paced_byte(pick_plain(), 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_messages();
    test_output_holdoff();
    test_raw_noise();
    $display("ran %0d requests in %0d messages, %0d decoded bytes checked", n_requests,
             n_messages, n_results);
    $display("included leading digits, saturated counts, long output hold-off and raw noise");
    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display("decimal_run_length_decoder_top_tb: PASS");
    end else begin
      $display("decimal_run_length_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
